// ===== sv/ewpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewpd_pkg
// Shared types and codes for the encoded word payload decoder.
// ----------------------------------------------------------------------------
package ewpd_pkg;

	// decode_mode codes
	localparam logic [1:0] MODE_B   = 2'd0;
	localparam logic [1:0] MODE_Q   = 2'd1;
	localparam logic [1:0] MODE_RAW = 2'd2;

	// register indexes (taken from paddr bit 2)
	localparam logic REG_DECODE_MODE  = 1'b0;
	localparam logic REG_CHARSET_MODE = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_BYTES   = 4;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);

	// decoded bytes of one item, before any latin-1 expansion
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      last;
	} entry_t;

endpackage

// ===== sv/ewpd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewpd_front
// Accepts payload characters, runs the B / Q / raw decode state and writes
// the bytes of each item that has bytes or is last as one entry.
// ----------------------------------------------------------------------------
module ewpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              last_in,
	input  logic [1:0]        decode_mode,
	output logic              wr_en,
	output ewpd_pkg::entry_t  wr_entry
);

	localparam logic [7:0] CHAR_EQ = 8'h3D;
	localparam logic [7:0] CHAR_US = 8'h5F;
	localparam logic [7:0] CHAR_SP = 8'h20;

	logic [20:0] hold_q, hold_d;
	logic [1:0]  gc_q, gc_d;
	logic        stop_q, stop_d;
	logic [1:0]  esc_q, esc_d;
	logic [7:0]  eh_q, eh_d;

	logic [ewpd_pkg::MAX_BYTES-1:0][7:0] bytes;
	logic [ewpd_pkg::CNT_W-1:0]          n;
	logic [6:0] sym, slot, sa, sb, sc;

	// {valid, value}
	function automatic logic [6:0] b64_sym(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h00;
		if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B) r = {1'b1, 6'd62};
		else if (c == 8'h2F) r = {1'b1, 6'd63};
		return r;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] r;
		if (c >= 8'h30 && c <= 8'h39) r = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) r = 4'(c - 8'h61 + 8'd10);
		else r = 4'(c - 8'h41 + 8'd10);
		return r;
	endfunction

	always_comb begin
		hold_d = hold_q;
		gc_d   = gc_q;
		stop_d = stop_q;
		esc_d  = esc_q;
		eh_d   = eh_q;
		bytes  = '0;
		n      = '0;
		sym    = b64_sym(in_byte);
		slot   = sym[6] ? sym : 7'h3F;
		sa     = hold_q[6:0];
		sb     = hold_q[13:7];
		sc     = hold_q[20:14];

		case (decode_mode)
			ewpd_pkg::MODE_B: begin
				if (!stop_q) begin
					if (gc_q != 2'd3) begin
						case (gc_q)
							2'd0: hold_d[6:0] = slot;
							2'd1: hold_d[13:7] = slot;
							default: hold_d[20:14] = slot;
						endcase
						gc_d = gc_q + 2'd1;
					end else begin
						gc_d = 2'd0;
						if (!sa[6] || !sb[6]) begin
							stop_d = 1'b1;
						end else begin
							bytes[n[1:0]] = {sa[5:0], sb[5:4]};
							n = n + 1'b1;
							if (sc[6]) begin
								bytes[n[1:0]] = {sb[3:0], sc[5:2]};
								n = n + 1'b1;
							end
							// a padding third character still feeds ones here
							if (sym[6]) begin
								bytes[n[1:0]] = {sc[1:0], sym[5:0]};
								n = n + 1'b1;
							end
						end
					end
				end
			end
			ewpd_pkg::MODE_Q: begin
				if (esc_q == 2'd1 && is_hex(in_byte)) begin
					eh_d  = in_byte;
					esc_d = 2'd2;
				end else if (esc_q == 2'd2 && is_hex(in_byte)) begin
					esc_d = 2'd0;
					bytes[n[1:0]] = {hex_val(eh_q), hex_val(in_byte)};
					n = n + 1'b1;
				end else begin
					// broken escape goes out literally, then the character itself
					esc_d = 2'd0;
					if (esc_q == 2'd1 || esc_q == 2'd2) begin
						bytes[n[1:0]] = CHAR_EQ;
						n = n + 1'b1;
					end
					if (esc_q == 2'd2) begin
						bytes[n[1:0]] = eh_q;
						n = n + 1'b1;
					end
					if (in_byte == CHAR_US) begin
						bytes[n[1:0]] = CHAR_SP;
						n = n + 1'b1;
					end else if (in_byte == CHAR_EQ) begin
						esc_d = 2'd1;
					end else begin
						bytes[n[1:0]] = in_byte;
						n = n + 1'b1;
					end
				end
			end
			default: begin
				bytes[n[1:0]] = in_byte;
				n = n + 1'b1;
			end
		endcase

		if (last_in) begin
			// flush an unfinished escape
			if (esc_d != 2'd0) begin
				bytes[n[1:0]] = CHAR_EQ;
				n = n + 1'b1;
			end
			if (esc_d == 2'd2) begin
				bytes[n[1:0]] = eh_d;
				n = n + 1'b1;
			end
			hold_d = '0;
			gc_d   = '0;
			stop_d = 1'b0;
			esc_d  = '0;
			eh_d   = '0;
		end
	end

	assign wr_en          = accept && (last_in || n != '0);
	assign wr_entry.bytes = bytes;
	assign wr_entry.count = n;
	assign wr_entry.last  = last_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			gc_q   <= '0;
			stop_q <= 1'b0;
			esc_q  <= '0;
			eh_q   <= '0;
		end else if (accept) begin
			hold_q <= hold_d;
			gc_q   <= gc_d;
			stop_q <= stop_d;
			esc_q  <= esc_d;
			eh_q   <= eh_d;
		end
	end

endmodule

// ===== sv/ewpd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewpd_queue
// Small entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module ewpd_queue #(
	parameter int QUEUE_DEPTH = ewpd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ewpd_pkg::entry_t  wr_entry,
	input  logic              rd_en,
	output logic              full,
	output logic              head_valid,
	output ewpd_pkg::entry_t  head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	ewpd_pkg::entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/ewpd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewpd_back
// Walks the bytes of the head entry, one result beat per cycle unless pop is low
// on a full output register, with optional latin-1 to utf-8 expansion, into that register.
// ----------------------------------------------------------------------------
module ewpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ewpd_pkg::entry_t  head,
	input  logic              charset_mode,
	output logic              rd_en,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              out_valid,
	output logic              out_last
);

	logic [1:0] idx_q;
	logic       half_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       valid_q, last_q;

	logic [7:0] cur, beat;
	logic       expand, final_beat, adv;

	always_comb begin
		cur    = head.bytes[idx_q];
		expand = charset_mode && cur[7];
		if (!expand) beat = cur;
		else if (!half_q) beat = {6'b110000, cur[7:6]};
		else beat = {2'b10, cur[5:0]};
		// empty end marker when the entry holds no bytes
		final_beat = (head.count == '0) ||
			(ewpd_pkg::CNT_W'(idx_q) == head.count - 1'b1 && (!expand || half_q));
	end

	assign adv   = !ov_q || pop;
	assign rd_en = head_valid && adv && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			half_q <= 1'b0;
			ov_q   <= 1'b0;
		end else if (adv) begin
			ov_q <= head_valid;
			if (head_valid) begin
				if (final_beat) begin
					idx_q  <= '0;
					half_q <= 1'b0;
				end else if (expand && !half_q) begin
					half_q <= 1'b1;
				end else begin
					idx_q  <= idx_q + 2'd1;
					half_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			byte_q  <= (head.count == '0) ? 8'h00 : beat;
			valid_q <= head.count != '0;
			last_q  <= head.last && final_beat;
		end
	end

	assign empty     = !ov_q;
	assign out_byte  = byte_q;
	assign out_valid = valid_q;
	assign out_last  = last_q;

endmodule

// ===== sv/encoded_word_payload_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoded_word_payload_decoder
// Decodes encoded word payload characters (base64, Q or raw) into bytes,
// optionally expanding latin-1 to utf-8.
//
//   channel   signals                                  beat taken when
//   input     push, full, in_byte, last_in             push && !full
//   result    pop, empty, out_byte, out_valid, out_last pop && !empty
//   config    psel, penable, pwrite, paddr, pwdata,    psel && penable &&
//             prdata, pready                           pwrite (pready high)
//
// an input beat is taken every cycle while the entry queue has room
// each item gives the back part 0 to 6 result beats
// (1 for an end marker, none for an item with no bytes that is not last);
// the back part's walk sets the sustained rate
// a result passes through the entry queue and the output register to the ports
// full rises while QUEUE_DEPTH entries wait; pop low holds the output register
// reset clears all decode state at once, no clearing pass
// ----------------------------------------------------------------------------
module encoded_word_payload_decoder #(
	parameter int QUEUE_DEPTH = ewpd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        last_in,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0] decode_mode_q;
	logic       charset_mode_q;
	logic       in_acc, q_wr, q_rd, q_head_valid;
	ewpd_pkg::entry_t q_wr_entry, q_head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= ewpd_pkg::MODE_B;
			charset_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				ewpd_pkg::REG_DECODE_MODE: decode_mode_q <= pwdata[1:0];
				default: charset_mode_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ewpd_pkg::REG_DECODE_MODE: prdata = {30'd0, decode_mode_q};
			default: prdata = {31'd0, charset_mode_q};
		endcase
	end

	assign in_acc = push && !full;

	ewpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.in_byte     (in_byte),
		.last_in     (last_in),
		.decode_mode (decode_mode_q),
		.wr_en       (q_wr),
		.wr_entry    (q_wr_entry)
	);

	ewpd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (q_wr),
		.wr_entry   (q_wr_entry),
		.rd_en      (q_rd),
		.full       (full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	ewpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.charset_mode (charset_mode_q),
		.rd_en        (q_rd),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.out_last     (out_last)
	);

	// an end marker always closes a word
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_valid) |-> out_last)
		else $error("end marker without out_last");

	a_rd_only_with_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_head_valid)
		else $error("queue read while empty");

	a_wr_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> (push && !full))
		else $error("queue write without an accepted input beat");

	// a last item always leaves an entry behind
	a_last_makes_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_in) |-> q_wr)
		else $error("last item produced no entry");

endmodule

// ===== verif/ewpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewpd_checker
// Watches the register, input and result channels of the encoded word payload
// decoder. Every accepted input beat is run through a local copy of the
// decoder (base64, Q or raw, with optional latin-1 to utf-8 expansion) and the
// bytes it should give are queued; each accepted result beat is compared,
// field by field, with the oldest of them.
// ----------------------------------------------------------------------------
module ewpd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  in_byte,
	input  logic        last_in,
	input  logic        pop,
	input  logic        empty,
	input  logic [7:0]  out_byte,
	input  logic        out_valid,
	input  logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          waiting,
	output int          errors
);

	localparam logic [6:0] SYM_NONE = 7'd64;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} beat_t;

	// register copies
	logic [1:0]  decode_mode_r;
	logic        latin1_r;

	// decode state
	logic [20:0] sextets;
	logic [1:0]  group_cnt;
	logic        b64_halt;
	logic [1:0]  esc_cnt;
	logic [7:0]  esc_digit;

	beat_t       expected_beats[$];
	beat_t       want;
	int          item_beats;
	int          err_count;

	function automatic logic [6:0] b64_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 7'(c - "A");
		if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
		if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
		if (c == "+") return 7'd62;
		if (c == "/") return 7'd63;
		return SYM_NONE;
	endfunction

	function automatic bit is_hex_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		return 4'(c - "A" + 10);
	endfunction

	task automatic queue_beat(input logic [7:0] b);
		expected_beats.push_back('{data: b, valid: 1'b1, last: 1'b0});
		item_beats++;
	endtask

	task automatic emit_byte(input logic [7:0] b);
		if (latin1_r && b[7]) begin
			queue_beat({6'b110000, b[7:6]});
			queue_beat({2'b10, b[5:0]});
		end else begin
			queue_beat(b);
		end
	endtask

	task automatic q_plain(input logic [7:0] c);
		if (c == "_")
			emit_byte(" ");
		else if (c == "=")
			esc_cnt = 2'd1;
		else
			emit_byte(c);
	endtask

	task automatic q_char(input logic [7:0] c);
		if (esc_cnt == 2'd1) begin
			if (is_hex_digit(c)) begin
				esc_digit = c;
				esc_cnt = 2'd2;
			end else begin
				esc_cnt = 2'd0;
				emit_byte("=");
				q_plain(c);
			end
		end else if (esc_cnt == 2'd2) begin
			esc_cnt = 2'd0;
			if (is_hex_digit(c)) begin
				emit_byte({hex_nibble(esc_digit), hex_nibble(c)});
			end else begin
				emit_byte("=");
				emit_byte(esc_digit);
				q_plain(c);
			end
		end else begin
			q_plain(c);
		end
	endtask

	task automatic b64_char(input logic [7:0] c);
		logic [6:0] v;
		logic [6:0] a;
		logic [6:0] b;
		logic [6:0] cc;
		if (b64_halt) return;
		v = (c == "=") ? SYM_NONE : b64_value(c);
		if (group_cnt < 2'd3) begin
			// padding or junk is held as all ones with the valid bit clear
			sextets[7*group_cnt +: 7] = (v == SYM_NONE) ? 7'h3F : {1'b1, v[5:0]};
			group_cnt = group_cnt + 2'd1;
		end else begin
			group_cnt = 2'd0;
			a = sextets[6:0];
			b = sextets[13:7];
			cc = sextets[20:14];
			if (!a[6] || !b[6]) begin
				b64_halt = 1'b1;
			end else begin
				emit_byte({a[5:0], b[5:4]});
				if (cc[6]) emit_byte({b[3:0], cc[5:2]});
				if (v != SYM_NONE) emit_byte({cc[1:0], v[5:0]});
			end
		end
	endtask

	task automatic decode_char(input logic [7:0] c, input logic is_last);
		beat_t tail;
		item_beats = 0;
		case (decode_mode_r)
			ewpd_pkg::MODE_B: b64_char(c);
			ewpd_pkg::MODE_Q: q_char(c);
			default: emit_byte(c);
		endcase
		if (is_last) begin
			// an unfinished escape goes out literally
			if (esc_cnt != 2'd0) begin
				emit_byte("=");
				if (esc_cnt == 2'd2) emit_byte(esc_digit);
			end
			sextets = '0;
			group_cnt = '0;
			b64_halt = 1'b0;
			esc_cnt = '0;
			esc_digit = '0;
			if (item_beats == 0) begin
				expected_beats.push_back('{data: 8'h00, valid: 1'b0, last: 1'b1});
			end else begin
				tail = expected_beats.pop_back();
				tail.last = 1'b1;
				expected_beats.push_back(tail);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_r = ewpd_pkg::MODE_B;
			latin1_r = 1'b0;
			sextets = '0;
			group_cnt = '0;
			b64_halt = 1'b0;
			esc_cnt = '0;
			esc_digit = '0;
			expected_beats.delete();
			err_count = 0;
			waiting <= 0;
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == ewpd_pkg::REG_DECODE_MODE)
					decode_mode_r = pwdata[1:0];
				else
					latin1_r = pwdata[0];
			end
			if (push && !full) decode_char(in_byte, last_in);
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result beat: got byte %02h valid %0b last %0b",
						$time, out_byte, out_valid, out_last);
				end else begin
					want = expected_beats.pop_front();
					if (out_byte !== want.data || out_valid !== want.valid ||
						out_last !== want.last) begin
						err_count++;
						$display("%0t: result mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
							$time, want.data, want.valid, want.last,
							out_byte, out_valid, out_last);
					end
				end
			end
			waiting <= expected_beats.size();
			errors <= err_count;
		end
	end

endmodule

// ===== verif/tb_encoded_word_payload_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoded_word_payload_decoder
// Drives encoded word payloads into the decoder: a few hand-picked words
// covering padding, stopped groups, Q escapes, mode changes mid-word and
// latin-1 expansion, then random words under every decode mode, with
// random idle bursts on both sides. Checking is done by ewpd_checker.
// ----------------------------------------------------------------------------
module tb_encoded_word_payload_decoder;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_DECODE_MODE = {ewpd_pkg::REG_DECODE_MODE, 2'b00};
	localparam logic [2:0] ADDR_CHARSET_MODE = {ewpd_pkg::REG_CHARSET_MODE, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        last_in = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        out_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	int          waiting;
	int          errors;

	logic [1:0]  cur_mode = ewpd_pkg::MODE_B;
	bit          tail_quiet = 1'b0;
	bit          input_idles = 1'b1;
	int          stall_left = 0;
	int          calm_left = 0;
	logic [7:0]  word_chars[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	encoded_word_payload_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte), .last_in(last_in),
		.pop(pop), .empty(empty), .out_byte(out_byte), .out_valid(out_valid),
		.out_last(out_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ewpd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte), .last_in(last_in),
		.pop(pop), .empty(empty), .out_byte(out_byte), .out_valid(out_valid),
		.out_last(out_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.waiting(waiting), .errors(errors)
	);

	// result side: stall bursts, calm stretches, none at the tail
	always @(posedge clk) begin
		int r;
		if (!arst_n || stall_left != 0) begin
			pop <= 1'b0;
			if (stall_left != 0) stall_left--;
		end else if (tail_quiet || calm_left != 0) begin
			pop <= 1'b1;
			if (calm_left != 0) calm_left--;
		end else begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				calm_left = $urandom_range(20, 120);
				pop <= 1'b1;
			end else if (r < 4) begin
				stall_left = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] rand_b64_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26) return 8'("A" + r);
		if (r < 52) return 8'("a" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return (r == 62) ? 8'("+") : 8'("/");
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return 8'("0" + r);
		if (r < 16) return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// drain the results, then give the back end time to finish silent items
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] c, input logic is_last);
		push <= 1'b1;
		in_byte <= c;
		last_in <= is_last;
		do @(posedge clk); while (full);
		if (input_idles && !tail_quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last_at_end && i == s.len() - 1);
	endtask

	task automatic make_b64_word();
		int groups;
		int r;
		groups = $urandom_range(0, 3);
		for (int g = 0; g < 4 * groups; g++) word_chars.push_back(rand_b64_char());
		r = $urandom_range(0, 7);
		case (r)
			0: begin
				repeat (2) word_chars.push_back(rand_b64_char());
				repeat (2) word_chars.push_back("=");
			end
			1: begin
				repeat (3) word_chars.push_back(rand_b64_char());
				word_chars.push_back("=");
			end
			2: repeat ($urandom_range(1, 3)) word_chars.push_back(rand_b64_char());
			3: begin
				// junk in the third and fourth place reads as padding unless it is a base64 character
				repeat (2) word_chars.push_back(rand_b64_char());
				repeat (2) word_chars.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		if (word_chars.size() == 0) word_chars.push_back(rand_b64_char());
		if ($urandom_range(0, 6) == 0)
			word_chars[$urandom_range(0, word_chars.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic make_q_word();
		int r;
		repeat ($urandom_range(1, 10)) begin
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2: begin
					word_chars.push_back("=");
					word_chars.push_back(rand_hex_char());
					word_chars.push_back(rand_hex_char());
				end
				3: word_chars.push_back("_");
				4: word_chars.push_back("=");
				5: begin
					word_chars.push_back("=");
					word_chars.push_back(rand_hex_char());
				end
				9: word_chars.push_back(8'($urandom_range(0, 255)));
				default: word_chars.push_back(8'($urandom_range(32, 126)));
			endcase
		end
	endtask

	task automatic make_word();
		word_chars.delete();
		case (cur_mode)
			ewpd_pkg::MODE_B: make_b64_word();
			ewpd_pkg::MODE_Q: make_q_word();
			default: repeat ($urandom_range(1, 8)) word_chars.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic run_phase(input logic [1:0] mode, input logic latin1, input bit quiet);
		int count;
		count = 0;
		settle();
		apb_write(ADDR_DECODE_MODE, {30'd0, mode});
		apb_write(ADDR_CHARSET_MODE, {31'd0, latin1});
		cur_mode = mode;
		tail_quiet = quiet;
		while (count < 22) begin
			make_word();
			input_idles = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < word_chars.size(); i++)
				send_char(word_chars[i], i == word_chars.size() - 1);
			count += word_chars.size();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base64 with latin-1 expansion: padded byte, padding third, stopped group
		apb_write(ADDR_DECODE_MODE, {30'd0, ewpd_pkg::MODE_B});
		apb_write(ADDR_CHARSET_MODE, 32'd1);
		send_text("/w==", 1'b1);
		send_text("AA=A", 1'b1);
		send_text("A*QJD", 1'b1);
		send_text("QU", 1'b0);

		// switch to Q mid-word; escape left open at the last beat
		settle();
		apb_write(ADDR_DECODE_MODE, {30'd0, ewpd_pkg::MODE_Q});
		apb_write(ADDR_CHARSET_MODE, 32'd0);
		send_text("=4", 1'b1);

		settle();
		apb_write(ADDR_CHARSET_MODE, 32'd1);
		send_text("=E9=Z=aG_", 1'b1);

		settle();
		apb_write(ADDR_DECODE_MODE, {30'd0, ewpd_pkg::MODE_RAW});
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);

		run_phase(ewpd_pkg::MODE_B, 1'b0, 1'b0);
		run_phase(ewpd_pkg::MODE_Q, 1'b1, 1'b0);
		run_phase(ewpd_pkg::MODE_RAW, 1'b0, 1'b0);
		run_phase(ewpd_pkg::MODE_B, 1'b1, 1'b0);
		run_phase(ewpd_pkg::MODE_Q, 1'b0, 1'b0);
		run_phase(MODE_UNUSED, 1'b1, 1'b0);
		run_phase(ewpd_pkg::MODE_RAW, 1'b1, 1'b0);
		run_phase(ewpd_pkg::MODE_B, 1'b1, 1'b1);

		push <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ewpd_pkg.sv
sv/ewpd_front.sv
sv/ewpd_queue.sv
sv/ewpd_back.sv
sv/encoded_word_payload_decoder.sv
verif/ewpd_checker.sv
verif/tb_encoded_word_payload_decoder.sv
